// File: design/cmrf_pkg.sv
package cmrf_pkg;

  localparam int TIME_W   = 63;
  localparam int OFFSET_W = 64;
  localparam int TRIP_W   = 31;

  localparam logic [TRIP_W-1:0] MAX_TRIP_RESET = 31'd100000;

  // kind field
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // running minimum that walks down the row of slot cells
  typedef struct packed {
    logic                go;
    logic                have;
    logic [TRIP_W-1:0]   trip;
    logic [OFFSET_W-1:0] offset;
  } scan_tok_t;

endpackage

// File: design/cmrf_ifs.sv
interface cmrf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [cmrf_pkg::TIME_W-1:0]    request_sent_time;
  logic [cmrf_pkg::TIME_W-1:0]    request_seen_time;
  logic [cmrf_pkg::TIME_W-1:0]    reply_sent_time;
  logic [cmrf_pkg::TIME_W-1:0]    reply_seen_time;

  modport source (output valid, kind, request_sent_time, request_seen_time,
                  reply_sent_time, reply_seen_time, input ready);
  modport sink (input valid, kind, request_sent_time, request_seen_time,
                reply_sent_time, reply_seen_time, output ready);
endinterface

interface cmrf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cmrf_pkg::OFFSET_W-1:0] clock_offset;
  logic [cmrf_pkg::TRIP_W-1:0]         best_round_trip;
  logic                                synced;
  logic                                sample_taken;

  modport source (output valid, clock_offset, best_round_trip, synced, sample_taken,
                  input ready);
  modport sink (input valid, clock_offset, best_round_trip, synced, sample_taken,
                output ready);
endinterface

interface cmrf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cmrf_pkg::TRIP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/cmrf_cell.sv
module cmrf_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [cmrf_pkg::OFFSET_W-1:0]  wr_offset,
  input  logic [cmrf_pkg::TRIP_W-1:0]    wr_trip,
  input  logic                           active,
  input  cmrf_pkg::scan_tok_t            tok_in,
  output cmrf_pkg::scan_tok_t            tok_out
);

  logic [cmrf_pkg::OFFSET_W-1:0] offset;
  logic [cmrf_pkg::TRIP_W-1:0]   trip;
  logic                          take_own;

  // strict less-than: on a tie the lower slot already in the token wins
  assign take_own = active && (!tok_in.have || (trip < tok_in.trip));

  always_ff @(posedge clk) begin
    if (we) begin
      offset <= wr_offset;
      trip   <= wr_trip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.go <= 1'b0;
    end else begin
      tok_out.go <= tok_in.go;
    end
    if (take_own) begin
      tok_out.have   <= 1'b1;
      tok_out.trip   <= trip;
      tok_out.offset <= offset;
    end else begin
      tok_out.have   <= tok_in.have;
      tok_out.trip   <= tok_in.trip;
      tok_out.offset <= tok_in.offset;
    end
  end

endmodule

// File: design/clock_offset_min_rtt_filter.sv
// Clock offset filter keeping the minimum round-trip sample.
//
// samples (sink): one item per two-way exchange, t1..t4 in microseconds, or a
//   clear item (kind = 1) that empties the window and drops sync.
// results (source): exactly one item per input item: offset and round trip of
//   the best held sample, synced flag, and whether this sample was taken.
// cfg (sink): writes max_round_trip; always ready, write only while idle.
//
// A taken sample goes from accept through the 64-bit sums, the 65-bit
//   differences and the limit check, then the running minimum walks the row of
//   slot cells, is latched, and loads the output register for results.valid.
//   Rejected and clear items skip the scan. One item is in flight at a time: no
//   new item is accepted until the last one has been loaded into the output register.
// The output register holds a finished item while the next item is accepted;
//   if results stalls, the block waits at its final step until the output
//   register frees, and samples.ready stays low meanwhile.
// Reset: window empty, not synced, max_round_trip = 100000, no result pending.
//   Slot contents are not cleared; only the filled count decides which slots
//   take part in the scan.
module clock_offset_min_rtt_filter #(
  parameter int WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst,
  cmrf_in_if.sink     samples,
  cmrf_out_if.source  results,
  cmrf_cfg_if.sink    cfg
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W = $clog2(WINDOW + 1);
  localparam int OW      = cmrf_pkg::OFFSET_W;
  localparam int TW      = cmrf_pkg::TRIP_W;
  localparam int XW      = cmrf_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;

  // captured item
  logic          kind;
  logic [XW-1:0] t1, t2, t3, t4;

  // pipeline of the exchange arithmetic
  logic [OW-1:0] late, early, ref_side, loc_side;  // exact 64-bit sums
  logic [OW:0]   trip_diff, off_diff;              // signed 65-bit differences

  logic [TW-1:0] max_round_trip;

  // window bookkeeping
  logic [SLOT_W-1:0]  write_slot;
  logic [COUNT_W-1:0] filled_count;
  logic [OW-1:0]      current_offset;
  logic [TW-1:0]      current_best_trip;
  logic               locked;
  logic               taken;
  logic               go0;

  logic          pass_check;
  logic [OW:0]   off_round;
  logic [OW-1:0] new_offset;
  logic [TW-1:0] new_trip;
  logic          wr_en;
  logic          out_free;

  cmrf_pkg::scan_tok_t tok [WINDOW+1];

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign out_free      = !results.valid || results.ready;

  // round trip must be non-negative and within the limit
  assign pass_check = !trip_diff[OW] &&
                      (trip_diff[OW-1:0] <= {{(OW-TW){1'b0}}, max_round_trip});
  assign new_trip   = trip_diff[TW-1:0];
  // halve toward zero: add one before the arithmetic shift when negative
  assign off_round  = off_diff + {{OW{1'b0}}, off_diff[OW]};
  assign new_offset = off_round[OW:1];
  assign wr_en      = (state == ST_DECIDE) && (kind == cmrf_pkg::KIND_SAMPLE) && pass_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_round_trip <= cmrf_pkg::MAX_TRIP_RESET;
    end else if (cfg.valid) begin
      max_round_trip <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      kind <= samples.kind;
      t1   <= samples.request_sent_time;
      t2   <= samples.request_seen_time;
      t3   <= samples.reply_sent_time;
      t4   <= samples.reply_seen_time;
    end
    if (state == ST_CALC) begin
      late     <= {1'b0, t4} + {1'b0, t2};
      early    <= {1'b0, t1} + {1'b0, t3};
      ref_side <= {1'b0, t2} + {1'b0, t3};
      loc_side <= {1'b0, t1} + {1'b0, t4};
    end
    if (state == ST_CHECK) begin
      trip_diff <= {1'b0, late} - {1'b0, early};
      off_diff  <= {1'b0, ref_side} - {1'b0, loc_side};
    end
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      write_slot        <= '0;
      filled_count      <= '0;
      current_offset    <= '0;
      current_best_trip <= '0;
      locked            <= 1'b0;
      taken             <= 1'b0;
      go0               <= 1'b0;
    end else begin
      go0 <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          taken <= wr_en;
          if (kind == cmrf_pkg::KIND_CLEAR) begin
            write_slot        <= '0;
            filled_count      <= '0;
            current_offset    <= '0;
            current_best_trip <= '0;
            locked            <= 1'b0;
            state             <= ST_DONE;
          end else if (wr_en) begin
            write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            if (filled_count != COUNT_W'(WINDOW)) begin
              filled_count <= filled_count + 1'b1;
            end
            go0   <= 1'b1;
            state <= ST_SCAN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          // minimum arrives at the end of the row
          if (tok[WINDOW].go) begin
            current_offset    <= tok[WINDOW].offset;
            current_best_trip <= tok[WINDOW].trip;
            locked            <= 1'b1;
            state             <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      results.clock_offset    <= current_offset;
      results.best_round_trip <= current_best_trip;
      results.synced          <= locked;
      results.sample_taken    <= taken;
    end
  end

  // row of slot cells; token enters at slot 0 and moves one slot per cycle
  assign tok[0].go     = go0;
  assign tok[0].have   = 1'b0;
  assign tok[0].trip   = '0;
  assign tok[0].offset = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_slot
    cmrf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .we        (wr_en && (write_slot == SLOT_W'(i))),
      .wr_offset (new_offset),
      .wr_trip   (new_trip),
      .active    (COUNT_W'(i) < filled_count),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  a_scan_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[WINDOW].go |-> state == ST_SCAN)
    else $error("scan token left the row outside the scan step");

  a_scan_has_sample: assert property (@(posedge clk) disable iff (rst)
    tok[WINDOW].go |-> tok[WINDOW].have)
    else $error("scan finished without any held sample");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= COUNT_W'(WINDOW))
    else $error("filled count beyond window");

  // during a scan the count already includes the new sample, sync follows at its end
  a_lock_matches_fill: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> locked == (filled_count != '0))
    else $error("synced flag disagrees with window fill");

  a_taken_synced: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.sample_taken |-> results.synced)
    else $error("taken sample reported without sync");

endmodule

// File: sim/clock_offset_min_rtt_filter_tb.sv
`timescale 1ns / 100ps

module clock_offset_min_rtt_filter_tb;

  localparam int TIME_W   = cmrf_pkg::TIME_W;
  localparam int TRIP_W   = cmrf_pkg::TRIP_W;
  localparam int OFFSET_W = cmrf_pkg::OFFSET_W;

  localparam int WINDOW = 8;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [TRIP_W-1:0] TRIP_MAX = {TRIP_W{1'b1}};

  // one input item: kind plus the four exchange timestamps
  typedef struct {
    logic              kind;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    logic [TIME_W-1:0] t3;
    logic [TIME_W-1:0] t4;
  } exchange_t;

  // one result item as the block should report it
  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [TRIP_W-1:0]   trip;
    logic                synced;
    logic                taken;
  } offset_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   reset_done = 1'b0;

  // idle knobs, flipped per test phase
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;

  int mismatch_count = 0;

  cmrf_in_if  samples_if ();
  cmrf_out_if results_if ();
  cmrf_cfg_if cfg_if ();

  clock_offset_min_rtt_filter #(
    .WINDOW(WINDOW)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .results(results_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: a ring of WINDOW (offset, round trip) pairs plus the reported
  // best. Only the first slots_filled slots ever take part in the min search.
  // ---------------------------------------------------------------------------
  logic [OFFSET_W-1:0] slot_offset [WINDOW];
  logic [TRIP_W-1:0]   slot_trip   [WINDOW];
  int                  next_slot;
  int                  slots_filled;
  logic [OFFSET_W-1:0] best_offset;
  logic [TRIP_W-1:0]   best_trip;
  logic                in_sync;
  logic [TRIP_W-1:0]   trip_limit;

  // reports owed by the block, oldest first
  offset_report_t offset_reports_due[$];

  function automatic offset_report_t predict_best_offset(exchange_t x);
    offset_report_t r;
    logic [63:0] late, early, ref_side, loc_side;
    int best;
    r.taken = 1'b0;
    if (x.kind == cmrf_pkg::KIND_CLEAR) begin
      next_slot    = 0;
      slots_filled = 0;
      best_offset  = '0;
      best_trip    = '0;
      in_sync      = 1'b0;
    end else begin
      // sums of two 63-bit times fit in 64 bits: everything is exact
      late  = {1'b0, x.t4} + {1'b0, x.t2};
      early = {1'b0, x.t1} + {1'b0, x.t3};
      if (late >= early && late - early <= {33'd0, trip_limit}) begin
        ref_side = {1'b0, x.t2} + {1'b0, x.t3};
        loc_side = {1'b0, x.t1} + {1'b0, x.t4};
        // halve the magnitude so the offset truncates toward zero
        slot_offset[next_slot] = (ref_side >= loc_side) ? (ref_side - loc_side) >> 1
                                                        : 64'd0 - ((loc_side - ref_side) >> 1);
        slot_trip[next_slot] = TRIP_W'(late - early);
        next_slot = (next_slot + 1) % WINDOW;
        if (slots_filled < WINDOW) slots_filled++;
        // strict less-than: on a tie the lowest slot keeps the win
        best = 0;
        for (int i = 1; i < slots_filled; i++)
          if (slot_trip[i] < slot_trip[best]) best = i;
        best_offset = slot_offset[best];
        best_trip   = slot_trip[best];
        in_sync     = 1'b1;
        r.taken     = 1'b1;
      end
    end
    r.offset = best_offset;
    r.trip   = best_trip;
    r.synced = in_sync;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready stalls drawn per item, and the checker.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    results_if.ready <= 1'b0;
    wait (reset_done);
    results_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) begin
        stall = rx_stalls_on ? $urandom_range(0, 14) : 0;
        // a zero stall keeps ready high: no drop and rise in one step
        if (stall > 0) begin
          results_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          results_if.ready <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    offset_report_t want;
    if (reset_done && results_if.valid && results_if.ready) begin
      if (offset_reports_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got offset %0h trip %0h synced %0b taken %0b",
                 $time, results_if.clock_offset, results_if.best_round_trip,
                 results_if.synced, results_if.sample_taken);
        mismatch_count++;
      end else begin
        want = offset_reports_due.pop_front();
        check_field("clock_offset", want.offset, results_if.clock_offset);
        check_field("best_round_trip", 64'(want.trip), 64'(results_if.best_round_trip));
        check_field("synced", 64'(want.synced), 64'(results_if.synced));
        check_field("sample_taken", 64'(want.taken), 64'(results_if.sample_taken));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // clock skew within about +-2^47 us
  function automatic logic signed [63:0] rand_skew();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {{16{r[47]}}, r[47:0]};
  endfunction

  // Drives one item after an optional gap, waits for acceptance, and books
  // the report it owes. valid stays high on return so back-to-back items
  // keep it up without a glitch.
  task automatic send_item(input logic kind, input logic [TIME_W-1:0] t1, t2, t3, t4);
    int gap;
    exchange_t x;
    gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x = '{kind, t1, t2, t3, t4};
    samples_if.valid             <= 1'b1;
    samples_if.kind              <= kind;
    samples_if.request_sent_time <= t1;
    samples_if.request_seen_time <= t2;
    samples_if.reply_sent_time   <= t3;
    samples_if.reply_seen_time   <= t4;
    do @(posedge clk); while (!samples_if.ready);
    offset_reports_due.push_back(predict_best_offset(x));
  endtask

  // Builds a plausible exchange: request leg + reply leg = trip, reference
  // clock ahead by skew, hold us spent at the reference. A negative trip
  // puts it all on the request leg.
  task automatic send_exchange(input logic [63:0] base, input logic signed [63:0] skew,
                               input logic signed [63:0] trip, input logic [31:0] hold);
    logic signed [63:0] out_leg, back_leg;
    logic [63:0] t2, t3, t4;
    out_leg  = (trip < 0) ? trip : 64'($urandom_range(0, trip[31:0]));
    back_leg = trip - out_leg;
    t2 = base + skew + out_leg;
    t3 = t2 + hold;
    t4 = t3 - skew + back_leg;
    send_item(cmrf_pkg::KIND_SAMPLE, base[TIME_W-1:0], t2[TIME_W-1:0], t3[TIME_W-1:0],
              t4[TIME_W-1:0]);
  endtask

  // Register writes only while the block holds nothing in flight.
  task automatic write_trip_limit(input logic [TRIP_W-1:0] limit);
    samples_if.valid <= 1'b0;
    while (offset_reports_due.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    trip_limit = limit;
  endtask

  task automatic pick_idle_mode();
    tx_gaps_on   = $urandom_range(0, 1);
    rx_stalls_on = $urandom_range(0, 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, truncation, boundary round trips, clear handling.
  task automatic test_edges();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    // rejected before any sample: reset state repeats; then two zero-trip samples
    send_item(cmrf_pkg::KIND_SAMPLE, 63'd5, 63'd0, 63'd0, 63'd0);
    send_item(cmrf_pkg::KIND_SAMPLE, '0, '0, '0, '0);
    send_item(cmrf_pkg::KIND_SAMPLE, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    // largest positive and negative offsets
    send_item(cmrf_pkg::KIND_SAMPLE, '0, TIME_MAX, TIME_MAX, '0);
    send_item(cmrf_pkg::KIND_SAMPLE, TIME_MAX, '0, '0, TIME_MAX);
    // odd negative sum: -7/2 must give -3
    send_item(cmrf_pkg::KIND_SAMPLE, 63'd3, 63'd0, 63'd0, 63'd4);
    // round trip right at the default limit, then one above
    send_item(cmrf_pkg::KIND_SAMPLE, 63'd0, 63'd0, 63'd0, 63'd100000);
    send_item(cmrf_pkg::KIND_SAMPLE, 63'd0, 63'd0, 63'd0, 63'd100001);
    send_item(cmrf_pkg::KIND_SAMPLE, rand_time(), rand_time(), rand_time(), rand_time());
    // clear ignores its timestamps; a rejected sample after it keeps sync low
    send_item(cmrf_pkg::KIND_CLEAR, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    send_item(cmrf_pkg::KIND_SAMPLE, 63'd9, 63'd0, 63'd0, 63'd1);
    send_item(cmrf_pkg::KIND_CLEAR, '0, '0, '0, '0);
  endtask

  // Fill past WINDOW so the oldest slots get overwritten; ties pick the
  // lower slot, and distinct skews make the chosen slot visible.
  task automatic test_window_ring();
    int trips[10] = '{50, 40, 40, 60, 30, 30, 70, 80, 90, 100};
    pick_idle_mode();
    send_item(cmrf_pkg::KIND_CLEAR, '0, '0, '0, '0);
    for (int k = 0; k < 10; k++)
      send_exchange(64'h0000_1000_0000_0000 + k * 64'd77, 64'sd1000 * (k + 1),
                    64'(trips[k]), $urandom_range(0, 500));
  endtask

  // Limit register at both ends.
  task automatic test_limit_register();
    write_trip_limit('0);
    pick_idle_mode();
    send_exchange(rand_time() >> 1, rand_skew(), 64'sd0, 32'd10);
    send_exchange(rand_time() >> 1, rand_skew(), 64'sd1, 32'd10);
    send_exchange(rand_time() >> 1, rand_skew(), 64'sd0, 32'd10);
    send_item(cmrf_pkg::KIND_CLEAR, rand_time(), rand_time(), rand_time(), rand_time());
    write_trip_limit(TRIP_MAX);
    send_exchange(rand_time() >> 1, rand_skew(), 64'(TRIP_MAX), 32'd0);
    send_exchange(rand_time() >> 1, rand_skew(), 64'(TRIP_MAX) + 1, 32'd0);
  endtask

  // Mostly well-formed exchanges with trips at the limit, just above it, negative,
  // at ties and below it, with clears and raw noise mixed in. The limit moves per block.
  task automatic test_random_traffic();
    logic [TRIP_W-1:0] limit;
    logic signed [63:0] trip;
    int pick;
    for (int blk = 0; blk < 15; blk++) begin
      case ($urandom_range(0, 4))
        0:       limit = TRIP_W'($urandom_range(0, 1000));
        1:       limit = cmrf_pkg::MAX_TRIP_RESET;
        2:       limit = TRIP_MAX;
        default: limit = TRIP_W'($urandom);
      endcase
      write_trip_limit(limit);
      pick_idle_mode();
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(cmrf_pkg::KIND_CLEAR, rand_time(), rand_time(), rand_time(), rand_time());
        end else if (pick < 12) begin
          send_item(cmrf_pkg::KIND_SAMPLE, rand_time(), rand_time(), rand_time(),
                    rand_time());
        end else begin
          case ($urandom_range(0, 9))
            0:       trip = 64'(limit);
            1:       trip = 64'(limit) + 1;
            2:       trip = 64'd0 - 64'($urandom_range(1, 5000));
            3, 4:    trip = 64'($urandom_range(0, 3));
            default: trip = 64'($urandom_range(0, limit));
          endcase
          send_exchange(rand_time() >> 1, rand_skew(), trip, $urandom_range(0, 1000000));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    samples_if.valid             <= 1'b0;
    samples_if.kind              <= cmrf_pkg::KIND_SAMPLE;
    samples_if.request_sent_time <= '0;
    samples_if.request_seen_time <= '0;
    samples_if.reply_sent_time   <= '0;
    samples_if.reply_seen_time   <= '0;
    cfg_if.valid                 <= 1'b0;
    cfg_if.data                  <= '0;

    next_slot    = 0;
    slots_filled = 0;
    best_offset  = '0;
    best_trip    = '0;
    in_sync      = 1'b0;
    trip_limit   = cmrf_pkg::MAX_TRIP_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    test_edges();
    test_window_ring();
    test_limit_register();
    test_random_traffic();

    // drain, then wait longer than a full scan for stray items
    samples_if.valid <= 1'b0;
    while (offset_reports_due.size() != 0) @(posedge clk);
    repeat (2 * WINDOW + 12) @(posedge clk);

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // a run that hangs past this timeout is reported as failed
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
design/cmrf_pkg.sv
design/cmrf_ifs.sv
design/cmrf_cell.sv
design/clock_offset_min_rtt_filter.sv
sim/clock_offset_min_rtt_filter_tb.sv
